@@ rtl/wmcd_pkg.sv @@
// Package for the weighted modulus check digit block: types, codes and constants.
`default_nettype none
package wmcd_pkg;

  // Field widths
  localparam int unsigned CharW   = 8;
  localparam int unsigned WeightW = 7;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ModW    = 8;
  localparam int unsigned CodeW   = 3;
  localparam int unsigned SumW    = 18;
  localparam int unsigned ProdW   = 11;
  localparam int unsigned StepW   = $clog2(SumW);
  localparam int unsigned AddrW   = 3;

  // Reciprocal of ten, exact for operands below 16384
  localparam int unsigned RecipW     = 13;
  localparam int unsigned RecipShift = 16;
  localparam logic [RecipW-1:0] Recip10 = RecipW'(6554);

  localparam logic [CharW-1:0] CharZero = 8'h30;
  localparam logic [CharW-1:0] CharNine = 8'h39;
  localparam logic [SumW-1:0]  SumMax   = {SumW{1'b1}};

  // Status codes
  localparam logic [StatusW-1:0] StPass       = 3'd0;
  localparam logic [StatusW-1:0] StFail       = 3'd1;
  localparam logic [StatusW-1:0] StBadModulus = 3'd2;
  localparam logic [StatusW-1:0] StNonNumeric = 3'd3;
  localparam logic [StatusW-1:0] StNoWeight   = 3'd4;
  localparam logic [StatusW-1:0] StBadCode    = 3'd5;

  // Two-digit handling codes
  localparam logic [CodeW-1:0] ActError     = 3'd1;
  localparam logic [CodeW-1:0] ActCrossfoot = 3'd2;
  localparam logic [CodeW-1:0] ActZero      = 3'd3;

  // Configuration register indexes
  localparam logic [AddrW-1:0] CfgModulus   = 3'd0;
  localparam logic [AddrW-1:0] CfgWeighting = 3'd1;
  localparam logic [AddrW-1:0] CfgCrossfoot = 3'd2;
  localparam logic [AddrW-1:0] CfgCodeEqual = 3'd3;
  localparam logic [AddrW-1:0] CfgCodeOther = 3'd4;

  typedef enum logic [1:0] {
    StIdle,
    StAcc,
    StDiv,
    StFin
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic acc;
    logic div_step;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic item_last;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/wmcd_ctrl.sv @@
// Controller state machine: sequences accumulate, remainder and finish steps.
`default_nettype none
module wmcd_ctrl import wmcd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = stat_i.item_last ? StDiv : StAcc;
        end
      end
      StAcc: state_d = StIdle;
      StDiv: begin
        if (stat_i.div_done) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (stat_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Commands
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      StAcc:  cmd_o.acc      = 1'b1;
      StDiv:  cmd_o.div_step = 1'b1;
      StFin:  cmd_o.finish   = stat_i.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/wmcd_dpath.sv @@
// Datapath: configuration, digit accumulation, bit-serial remainder and result register.
`default_nettype none
module wmcd_dpath import wmcd_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 256
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_valid_i,
  input  wire logic [AddrW-1:0]     cfg_addr_i,
  input  wire logic [ModW-1:0]      cfg_data_i,
  // input word fields
  input  wire logic [CharW-1:0]     char_code_i,
  input  wire logic [WeightW-1:0]   weight_i,
  input  wire logic                 weight_present_i,
  input  wire logic                 last_i,
  // result word
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [StatusW-1:0]        status_o,
  output logic [CharW-1:0]          expected_digit_o,
  // control
  input  wire cmd_t                 cmd_i,
  output stat_t                     stat_o
);

  localparam int unsigned CntW = $clog2(MAX_DIGITS);
  localparam logic [CntW-1:0] CntLimit = CntW'(MAX_DIGITS - 1);

  // Configuration registers
  logic [ModW-1:0]  modulus_q;
  logic             weighting_q, crossfoot_q;
  logic [CodeW-1:0] code_equal_q, code_other_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q    <= ModW'(10);
      weighting_q  <= 1'b0;
      crossfoot_q  <= 1'b0;
      code_equal_q <= ActError;
      code_other_q <= ActError;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CfgModulus:   modulus_q    <= cfg_data_i;
        CfgWeighting: weighting_q  <= cfg_data_i[0];
        CfgCrossfoot: crossfoot_q  <= cfg_data_i[0];
        CfgCodeEqual: code_equal_q <= cfg_data_i[CodeW-1:0];
        CfgCodeOther: code_other_q <= cfg_data_i[CodeW-1:0];
        default: ;
      endcase
    end
  end

  // Item registers: the weighted product is formed at acceptance
  logic [CharW-1:0] char_q;
  logic [ProdW-1:0] prod_q;
  logic             wp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      char_q <= char_code_i;
      prod_q <= ProdW'(char_code_i[3:0]) * ProdW'(weight_i);
      wp_q   <= weight_present_i;
    end
  end

  // Field state and remainder registers
  logic [SumW-1:0]    sum_q;
  logic [StatusW-1:0] sticky_q;
  logic [CntW-1:0]    cnt_q;
  logic [ModW-1:0]    rem_q;
  logic [StepW-1:0]   step_q;
  logic [ModW:0]      shifted;

  // Crossfoot the product: tens plus units
  logic [ProdW+RecipW-1:0] p_scaled;
  logic [ProdW-1:0]        p_tens, p_units, p_cross;
  always_comb begin
    p_scaled = (ProdW+RecipW)'(prod_q) * (ProdW+RecipW)'(Recip10);
    p_tens   = ProdW'(p_scaled >> RecipShift);
    p_units  = prod_q - ((p_tens << 3) + (p_tens << 1));
    p_cross  = p_tens + p_units;
  end

  // Work out the addend and any data error
  logic             is_digit;
  logic [ProdW-1:0] addend;
  logic [SumW:0]    sum_ext;
  always_comb begin
    is_digit = (char_q >= CharZero) && (char_q <= CharNine);
    if (!weighting_q) begin
      addend = ProdW'(char_q[3:0]);
    end else if (crossfoot_q && (prod_q > ProdW'(9))) begin
      addend = p_cross;
    end else begin
      addend = prod_q;
    end
    sum_ext = {1'b0, sum_q} + (SumW+1)'(addend);
  end

  // Field state and bit-serial remainder
  assign shifted = {rem_q, sum_q[SumW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      sticky_q <= StPass;
      cnt_q    <= '0;
      rem_q    <= '0;
      step_q   <= '0;
    end else if (cmd_i.finish) begin
      sum_q    <= '0;
      sticky_q <= StPass;
      cnt_q    <= '0;
    end else if (cmd_i.load_item) begin
      rem_q  <= '0;
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      // one remainder bit per cycle, dividend shifts out of the sum
      sum_q  <= sum_q << 1;
      step_q <= step_q + StepW'(1);
      if (shifted >= {1'b0, modulus_q}) begin
        rem_q <= ModW'(shifted - {1'b0, modulus_q});
      end else begin
        rem_q <= shifted[ModW-1:0];
      end
    end else if (cmd_i.acc && (sticky_q == StPass) && (cnt_q < CntLimit)) begin
      if (!is_digit) begin
        sticky_q <= StNonNumeric;
      end else if (weighting_q && !wp_q) begin
        sticky_q <= StNoWeight;
      end else begin
        sum_q <= sum_ext[SumW] ? SumMax : sum_ext[SumW-1:0];
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  // Check value and its two-digit handling
  logic [ModW-1:0]        val, v_tens, v_units, val_fin;
  logic [ModW+RecipW-1:0] v_scaled;
  logic [CodeW-1:0]       action;
  logic [StatusW-1:0]     res_status;
  logic [CharW-1:0]       res_exp;
  logic [CharW-1:0]       char_off;
  always_comb begin
    val      = modulus_q - rem_q;
    v_scaled = (ModW+RecipW)'(val) * (ModW+RecipW)'(Recip10);
    v_tens   = ModW'(v_scaled >> RecipShift);
    v_units  = val - ((v_tens << 3) + (v_tens << 1));
    action   = (val == modulus_q) ? code_equal_q : code_other_q;
    char_off = char_q - CharZero;
    val_fin  = val;
    res_exp  = '0;
    res_status = StPass;
    if (modulus_q == '0) begin
      res_status = StBadModulus;
    end else if (sticky_q != StPass) begin
      res_status = sticky_q;
    end else begin
      if (val > ModW'(9)) begin
        case (action)
          ActError:     res_status = StFail;
          ActCrossfoot: val_fin    = v_tens + v_units;
          ActZero:      val_fin    = '0;
          default:      res_status = StBadCode;
        endcase
      end
      if (res_status == StPass) begin
        res_exp    = val_fin;
        res_status = ((char_q >= CharZero) && (char_off == val_fin)) ? StPass : StFail;
      end
    end
  end

  // Result register: holds a word until taken
  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [CharW-1:0]   out_exp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_status_q <= res_status;
      out_exp_q    <= res_exp;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign expected_digit_o = out_exp_q;

  // Status to the controller
  assign stat_o.item_last = last_i;
  assign stat_o.div_done  = (step_q == StepW'(SumW - 1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire

@@ rtl/weighted_modulus_check_digit_core.sv @@
// A data word is accepted, then accumulated into the field sum; a check word is
// accepted, then its remainder is worked out in the bit-serial remainder unit
// (one bit of the 18-bit sum per cycle), and the result is registered on finish.
// The input takes no new word until the current one is done; a check word holds the input
// longer while the previous result still waits to be taken.
// Reset (rst_ni low, asynchronous) clears the field state and restores registers.
`default_nettype none
module weighted_modulus_check_digit_core import wmcd_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [7:0]  cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [7:0] char_code, [14:8] weight, [15] zero
  input  wire logic        s_axis_tuser_i,   // [0] weight_present
  input  wire logic        s_axis_tlast_i,
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o    // [2:0] status, [10:3] expected_digit, [15:11] zero
);

  cmd_t               cmd;
  stat_t              stat;
  logic [StatusW-1:0] status;
  logic [CharW-1:0]   expected_digit;
  logic               pad_unused;

  assign cfg_ready_o = 1'b1;
  assign pad_unused  = s_axis_tdata_i[15];

  wmcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wmcd_dpath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_data_i       (cfg_data_i),
    .char_code_i      (s_axis_tdata_i[7:0]),
    .weight_i         (s_axis_tdata_i[14:8]),
    .weight_present_i (s_axis_tuser_i),
    .last_i           (s_axis_tlast_i),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .status_o         (status),
    .expected_digit_o (expected_digit),
    .cmd_i            (cmd),
    .stat_o           (stat)
  );

  // Pack the result word, padding bits tied low
  assign m_axis_tdata_o = {5'b0 & {5{pad_unused}}, expected_digit, status};

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the weighted modulus check digit core.
module tb;
  import wmcd_pkg::*;

  localparam int MaxDigits    = 256;
  localparam int PhaseWords   = 135;
  localparam int SettleCycles = 30;
  localparam int HoldCycles   = 400;
  localparam int CycleLimit   = 400000;

  // One character word as offered on the input stream
  typedef struct packed {
    logic [CharW-1:0]   ch_code;
    logic [WeightW-1:0] weight;
    logic               weight_present;
    logic               last;
  } item_t;

  // Verdict for one field
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CharW-1:0]   digit;
  } verdict_t;

  // Running state of the field being checked
  typedef struct {
    int                 sum;
    logic [StatusW-1:0] err;
    int                 count;
  } field_t;

  typedef struct {
    logic [ModW-1:0]  modulus;
    logic             weighting;
    logic             crossfoot;
    logic [CodeW-1:0] code_eq;
    logic [CodeW-1:0] code_other;
  } regs_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_addr_i;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;   // [7:0] char_code, [14:8] weight, [15] zero
  logic        s_axis_tuser_i;   // [0] weight_present
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;   // [2:0] status, [10:3] expected_digit, [15:11] zero

  item_t    word_queue[$];
  verdict_t verdict_queue[$];
  field_t   field_state;
  regs_t    model_regs;

  int send_idle = 8;
  int recv_idle = 63;
  int hold_left = 0;
  bit in_took   = 1'b0;
  int err_count = 0;
  int words_in  = 0;
  int verdicts  = 0;
  int passes    = 0;
  int reg_writes = 0;
  int cycles    = 0;

  weighted_modulus_check_digit_core #(
    .MAX_DIGITS(MaxDigits)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Fold one data character into the field sum; the first error sticks
  function automatic void accumulate_digit(inout field_t f, input item_t it);
    int d;
    if (f.err != StPass || f.count >= MaxDigits - 1) return;
    if (it.ch_code < CharZero || it.ch_code > CharNine) begin
      f.err = StNonNumeric;
      return;
    end
    d = int'(it.ch_code) - int'(CharZero);
    if (model_regs.weighting) begin
      if (!it.weight_present) begin
        f.err = StNoWeight;
        return;
      end
      d = d * int'(it.weight);
      if (model_regs.crossfoot && d > 9) d = d / 10 + d % 10;
    end
    f.sum = f.sum + d;
    if (f.sum > int'(SumMax)) f.sum = int'(SumMax);
    f.count++;
  endfunction

  // Work out the field verdict from the check character, then clear the field
  function automatic verdict_t close_field(inout field_t f, input logic [CharW-1:0] ch);
    verdict_t         v;
    int               val;
    logic [CodeW-1:0] act;
    v.status = StPass;
    v.digit  = '0;
    if (model_regs.modulus == '0) begin
      v.status = StBadModulus;
    end else if (f.err != StPass) begin
      v.status = f.err;
    end else begin
      val = int'(model_regs.modulus) - f.sum % int'(model_regs.modulus);
      if (val > 9) begin
        act = (val == int'(model_regs.modulus)) ? model_regs.code_eq : model_regs.code_other;
        case (act)
          ActError: begin
            v.status = StFail;
            val = -1;
          end
          ActCrossfoot: val = val / 10 + val % 10;
          ActZero:      val = 0;
          default: begin
            v.status = StBadCode;
            val = -1;
          end
        endcase
      end
      if (val >= 0) begin
        v.digit  = val[CharW-1:0];
        v.status = (ch >= CharZero && int'(ch) - int'(CharZero) == val) ? StPass : StFail;
      end
    end
    f.sum   = 0;
    f.err   = StPass;
    f.count = 0;
    return v;
  endfunction

  // Input driver: present the next word once the current one has gone
  always @(negedge clk_i) begin
    item_t nxt;
    if (!s_axis_tvalid_i || in_took) begin
      if (rst_ni && word_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
        nxt = word_queue.pop_front();
        s_axis_tdata_i  <= {1'b0, nxt.weight, nxt.ch_code};
        s_axis_tuser_i  <= nxt.weight_present;
        s_axis_tlast_i  <= nxt.last;
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Result receiver: long hold-off when asked, random stalls otherwise
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Monitor: check result words, then predict from accepted input words
  always @(posedge clk_i) begin
    item_t    seen;
    verdict_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (verdict_queue.size() == 0) begin
        $display("%0t: result word with nothing expected, got status %0d digit %0d",
                 $time, m_axis_tdata_o[2:0], m_axis_tdata_o[10:3]);
        err_count++;
      end else begin
        want = verdict_queue.pop_front();
        verdicts++;
        if (want.status == StPass) passes++;
        if (m_axis_tdata_o[2:0] != want.status) begin
          $display("%0t: status mismatch, expected %0d got %0d",
                   $time, want.status, m_axis_tdata_o[2:0]);
          err_count++;
        end
        if (m_axis_tdata_o[10:3] != want.digit) begin
          $display("%0t: expected_digit mismatch, expected %0d got %0d",
                   $time, want.digit, m_axis_tdata_o[10:3]);
          err_count++;
        end
      end
    end
    in_took = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (in_took) begin
      seen.ch_code        = s_axis_tdata_i[7:0];
      seen.weight         = s_axis_tdata_i[14:8];
      seen.weight_present = s_axis_tuser_i;
      seen.last           = s_axis_tlast_i;
      words_in++;
      if (seen.last) verdict_queue.push_back(close_field(field_state, seen.ch_code));
      else accumulate_digit(field_state, seen);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_word(input logic [7:0] ch, input logic [6:0] w, input logic wp,
                           input logic last);
    item_t it;
    it.ch_code        = ch;
    it.weight         = w;
    it.weight_present = wp;
    it.last           = last;
    word_queue.push_back(it);
  endtask

  // Queue a field of n data words and a check word, usually the right one
  task automatic add_field(input int n, input int noise_pct);
    field_t   g;
    item_t    it;
    verdict_t v;
    int       r;
    g.sum   = 0;
    g.err   = StPass;
    g.count = 0;
    for (int i = 0; i < n; i++) begin
      it.ch_code        = ($urandom_range(99) < noise_pct) ? 8'($urandom_range(255))
                                                           : CharZero + 8'($urandom_range(9));
      it.weight         = 7'($urandom_range(99));
      it.weight_present = ($urandom_range(99) >= 3);
      it.last           = 1'b0;
      accumulate_digit(g, it);
      word_queue.push_back(it);
    end
    v = close_field(g, 8'h00);
    r = $urandom_range(99);
    if (r < 65 && v.digit <= 8'd207) it.ch_code = CharZero + v.digit;
    else if (r < 80) it.ch_code = CharZero + 8'($urandom_range(9));
    else it.ch_code = 8'($urandom_range(255));
    it.weight         = 7'($urandom_range(99));
    it.weight_present = 1'($urandom_range(1));
    it.last           = 1'b1;
    word_queue.push_back(it);
  endtask

  task automatic fill_words(input int total);
    int sent;
    sent = 0;
    while (sent < total) begin
      automatic int n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
      add_field(n, ($urandom_range(9) == 0) ? 30 : 2);
      sent += n + 1;
    end
  endtask

  // Wait until the input is empty and every verdict has come back
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (word_queue.size() != 0 || s_axis_tvalid_i || verdict_queue.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [AddrW-1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      CfgModulus:   model_regs.modulus    = val;
      CfgWeighting: model_regs.weighting  = val[0];
      CfgCrossfoot: model_regs.crossfoot  = val[0];
      CfgCodeEqual: model_regs.code_eq    = val[CodeW-1:0];
      CfgCodeOther: model_regs.code_other = val[CodeW-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Write all registers; unused upper bits carry noise
  task automatic set_regs(input logic [7:0] m, input logic w, input logic cf,
                          input logic [2:0] ce, input logic [2:0] co);
    write_reg(CfgModulus, m);
    write_reg(CfgWeighting, (8'($urandom_range(255)) & 8'hFE) | 8'(w));
    write_reg(CfgCrossfoot, (8'($urandom_range(255)) & 8'hFE) | 8'(cf));
    write_reg(CfgCodeEqual, (8'($urandom_range(255)) & 8'hF8) | 8'(ce));
    write_reg(CfgCodeOther, (8'($urandom_range(255)) & 8'hF8) | 8'(co));
  endtask

  function automatic logic [2:0] pick_code();
    return ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 3));
  endfunction

  initial begin
    logic [7:0] m;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_addr_i      = '0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    model_regs.modulus    = 8'd10;
    model_regs.weighting  = 1'b0;
    model_regs.crossfoot  = 1'b0;
    model_regs.code_eq    = ActError;
    model_regs.code_other = ActError;
    field_state.sum   = 0;
    field_state.err   = StPass;
    field_state.count = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed fields at the reset settings
    push_word(8'h30, 7'd0, 1'b0, 1'b1);                  // empty field, two-digit value
    push_word(8'h37, 7'd0, 1'b0, 1'b0);
    push_word(8'h39, 7'd99, 1'b1, 1'b0);
    push_word(8'h34, 7'd0, 1'b0, 1'b1);                  // matching check digit
    push_word(8'h39, 7'd99, 1'b0, 1'b0);                 // weights ignored when off
    push_word(8'h39, 7'd64, 1'b1, 1'b0);
    push_word(8'h39, 7'd127, 1'b0, 1'b0);
    push_word(8'hFF, 7'd0, 1'b1, 1'b1);                  // wrong check character
    push_word(8'h2F, 7'd0, 1'b0, 1'b0);                  // just below '0'
    push_word(8'h35, 7'd0, 1'b0, 1'b0);                  // ignored after the error
    push_word(8'h30, 7'd0, 1'b0, 1'b1);
    push_word(8'h3A, 7'd0, 1'b0, 1'b0);                  // just above '9'
    push_word(8'h00, 7'd0, 1'b0, 1'b1);
    push_word(8'h00, 7'd0, 1'b0, 1'b0);
    push_word(8'hFF, 7'd0, 1'b0, 1'b0);
    push_word(8'h35, 7'd0, 1'b0, 1'b1);
    push_word(8'h35, 7'd0, 1'b0, 1'b0);
    push_word(8'h35, 7'd0, 1'b0, 1'b1);                  // pass
    push_word(8'h30, 7'd0, 1'b0, 1'b0);
    push_word(8'h2F, 7'd0, 1'b0, 1'b1);                  // check char below '0'

    // Random phases, each at its own register setting
    for (int ph = 0; ph < 12; ph++) begin
      wait_quiet();
      case (ph)
        0: set_regs(8'd11, 1'b1, 1'b1, ActZero, ActCrossfoot);
        1: set_regs(8'd0, 1'b1, 1'b0, 3'd0, 3'd7);
        2: set_regs(8'd255, 1'b1, 1'b0, ActCrossfoot, ActZero);
        3: set_regs(8'd1, 1'b0, 1'b1, 3'd7, 3'd0);
        4: set_regs(8'd99, 1'b0, 1'b0, 3'd5, 3'd0);
        default: begin
          m = ($urandom_range(15) == 0) ? 8'd0 :
              ($urandom_range(3) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(2, 20));
          set_regs(m, 1'($urandom_range(1)), 1'($urandom_range(1)), pick_code(), pick_code());
        end
      endcase
      @(posedge clk_i);
      send_idle = (ph < 4) ? 8 : (ph < 8) ? 63 : 0;
      recv_idle = (ph < 4) ? 63 : (ph < 8) ? 8 : 0;
      fill_words(PhaseWords / 2);
      // Overlong field: digits beyond the limit are dropped
      if (ph == 2) add_field(300, 0);
      // Hold the result side off while input keeps coming, to fill the block
      if (ph == 1 || ph == 9) begin
        @(posedge clk_i);
        hold_left = HoldCycles;
      end
      // Pause the input until all verdicts are home
      if (ph == 6) wait_quiet();
      fill_words(PhaseWords - PhaseWords / 2);
    end

    wait_quiet();
    $display("Covered %0d input words, %0d field verdicts (%0d passing), %0d register writes",
             words_in, verdicts, passes, reg_writes);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/wmcd_pkg.sv
rtl/wmcd_ctrl.sv
rtl/wmcd_dpath.sv
rtl/weighted_modulus_check_digit_core.sv
dv/tb.sv
